>>> rtl/cca_pkg.sv
// Package for the cluster chain address walker.
// Holds opcodes, status codes, sequencer states and sizing constants.
// No dependencies.
package cca_pkg;

  localparam int unsigned FatEntries  = 4096;
  localparam int unsigned FatAw       = $clog2(FatEntries);
  localparam int unsigned MaxSegments = 64;
  localparam int unsigned SegCntW     = $clog2(MaxSegments + 1);
  localparam int unsigned MaxShift    = 25;
  localparam int unsigned WalkCntW    = FatAw + 1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_END       = 3'd1,
    ST_INVALID   = 3'd2,
    ST_PREMATURE = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_SPC_SHIFT = 2'd0,
    CFG_BPS_SHIFT = 2'd1,
    CFG_TOTAL     = 2'd2,
    CFG_DATA_SEC  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_TAIL  = 2'd0,
    PH_CYCLE = 2'd1,
    PH_REST  = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OPEN_RD,
    S_OPEN_CHK,
    S_OPEN_DIV,
    S_TR_SEG,
    S_TR_RD,
    S_TR_CHK,
    S_TR_ADDR,
    S_TR_EMIT,
    S_WAIT
  } state_e;

endpackage

>>> rtl/cca_if.sv
// Channel interfaces of the cluster chain address walker.
// No dependencies.
interface cca_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [11:0] fat_index;
  logic [31:0] fat_value;
  logic [11:0] start_cluster;
  logic [47:0] start_position;
  logic [31:0] request_length;
  modport source (output valid, opcode, fat_index, fat_value, start_cluster,
                  start_position, request_length, input ready);
  modport sink (input valid, opcode, fat_index, fat_value, start_cluster,
                start_position, request_length, output ready);
endinterface

interface cca_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] segment_address;
  logic [25:0] segment_length;
  logic        is_write;
  logic [31:0] transferred;
  logic [2:0]  status;
  logic        last;
  modport source (output valid, segment_address, segment_length, is_write,
                  transferred, status, last, input ready);
  modport sink (input valid, segment_address, segment_length, is_write,
                transferred, status, last, output ready);
endinterface

interface cca_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/cluster_chain_address_walker.sv
// Top level of the cluster chain address walker: link table, sequencer, output register.
// Depends on cca_pkg and the interfaces in cca_if.sv.
//
// One item at a time. A table load is written while idle. Each link followed is a registered
// table read, then a check. A segment is formed in the address and emit states, preceded by a
// link read and check when the current cluster is used up, and waits until its beat is taken.
// Open walks at most 4096 links directly; longer walks find the cycle period, take the
// remainder with a serial divider, and walk at most period-1 more links.
// The single table read port sets the pace.
module cluster_chain_address_walker
  import cca_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  cca_cfg_if.sink   cfg_i,
  cca_in_if.sink    in_i,
  cca_out_if.source out_o
);

  logic [31:0] fat_q [FatEntries];
  logic [31:0] rdata_q;
  logic [FatAw-1:0] raddr;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [4:0]  spc_q;
  logic [3:0]  bps_q;
  logic [11:0] total_q;
  logic [31:0] dss_q;
  logic [31:0] cur_q, cur_d;
  logic [25:0] off_q, off_d;
  logic [FatAw-1:0] walk_q, walk_d, mark_q, mark_d, per_q, per_d;
  logic [WalkCntW-1:0] cnt_q, cnt_d, target_q, target_d;
  logic [47:0] pos_q, pos_d, n_q, n_d, num_q, num_d;
  logic [FatAw:0] rem_q, rem_d;
  logic [5:0]  dcnt_q, dcnt_d;
  logic [31:0] len_q, len_d, done_q, done_d;
  logic        wr_q, wr_d;
  logic [SegCntW-1:0] k_q, k_d;
  logic [25:0] remain_q, remain_d, seg_q, seg_d;
  logic [63:0] t_q, t_d;
  logic        ov_q, ov_d, ol_q, ol_d, ow_q, ow_d;
  logic [63:0] oa_q, oa_d;
  logic [25:0] olen_q, olen_d;
  logic [31:0] odone_q, odone_d;
  status_e     ost_q, ost_d;

  logic [5:0]  sh_sum;
  logic [4:0]  sh;
  logic [25:0] cs;
  logic [47:0] in_n;
  logic [31:0] nx;
  logic        nx_ok;
  logic [FatAw:0] rem_sh;
  logic [47:0] fin_off;
  logic [31:0] len_after;
  logic        in_acc;

  assign sh_sum = {1'b0, spc_q} + {2'b0, bps_q};
  assign sh     = (sh_sum > 6'(MaxShift)) ? 5'(MaxShift) : sh_sum[4:0];
  assign cs     = 26'd1 << sh;
  assign in_n   = (in_i.start_position > {22'b0, cs}) ?
                  ((in_i.start_position - 48'd1) >> sh) : 48'd0;
  assign in_acc = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Links for clusters beyond the table read as zero
  always_comb begin
    if ((state_q == S_TR_CHK) && (cur_q[31:FatAw] != '0)) nx = 32'd0;
    else nx = rdata_q;
  end
  assign nx_ok   = (nx >= 32'd2) && (nx <= ({20'b0, total_q} + 32'd1));
  assign raddr   = (state_q == S_TR_RD) ? cur_q[FatAw-1:0] : walk_q;
  assign rem_sh  = {rem_q[FatAw-1:0], num_q[47]};
  assign fin_off = pos_q - (n_q << sh);
  assign len_after = len_q - {6'b0, seg_q};

  always_ff @(posedge clk_i) begin
    if (in_acc && (opcode_e'(in_i.opcode) == OP_LOAD))
      fat_q[in_i.fat_index] <= in_i.fat_value;
    rdata_q <= fat_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_q   <= '0;
      bps_q   <= 4'd9;
      total_q <= '0;
      dss_q   <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_SPC_SHIFT: spc_q   <= cfg_i.data[4:0];
        CFG_BPS_SHIFT: bps_q   <= cfg_i.data[3:0];
        CFG_TOTAL:     total_q <= cfg_i.data[11:0];
        CFG_DATA_SEC:  dss_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_TAIL;
      cur_q   <= '0;
      off_q   <= '0;
      ov_q    <= 1'b0;
      ol_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cur_q   <= cur_d;
      off_q   <= off_d;
      ov_q    <= ov_d;
      ol_q    <= ol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q <= walk_d;  mark_q <= mark_d;  per_q <= per_d;
    cnt_q <= cnt_d;  target_q <= target_d;
    pos_q <= pos_d;  n_q <= n_d;  num_q <= num_d;  rem_q <= rem_d;  dcnt_q <= dcnt_d;
    len_q <= len_d;  done_q <= done_d;  wr_q <= wr_d;  k_q <= k_d;
    remain_q <= remain_d;  seg_q <= seg_d;  t_q <= t_d;
    oa_q <= oa_d;  olen_q <= olen_d;  ow_q <= ow_d;  odone_q <= odone_d;  ost_q <= ost_d;
  end

  always_comb begin
    state_d = state_q;  phase_d = phase_q;
    cur_d = cur_q;  off_d = off_q;
    walk_d = walk_q;  mark_d = mark_q;  per_d = per_q;
    cnt_d = cnt_q;  target_d = target_q;
    pos_d = pos_q;  n_d = n_q;  num_d = num_q;  rem_d = rem_q;  dcnt_d = dcnt_q;
    len_d = len_q;  done_d = done_q;  wr_d = wr_q;  k_d = k_q;
    remain_d = remain_q;  seg_d = seg_q;  t_d = t_q;
    ov_d = ov_q;  ol_d = ol_q;  oa_d = oa_q;  olen_d = olen_q;  ow_d = ow_q;
    odone_d = odone_q;  ost_d = ost_q;
    if (out_o.valid && out_o.ready) ov_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (opcode_e'(in_i.opcode))
            OP_LOAD: ;
            OP_OPEN: begin
              pos_d    = in_i.start_position;
              n_d      = in_n;
              walk_d   = in_i.start_cluster;
              cnt_d    = '0;
              phase_d  = PH_TAIL;
              target_d = (in_n > 48'(FatEntries)) ? WalkCntW'(FatEntries)
                                                  : in_n[WalkCntW-1:0];
              if (in_n == 48'd0) begin
                cur_d = {20'b0, in_i.start_cluster};
                off_d = in_i.start_position[25:0];
                oa_d = '0;  olen_d = '0;  ow_d = 1'b0;  odone_d = '0;
                ost_d = ST_OK;  ol_d = 1'b1;  ov_d = 1'b1;
                state_d = S_WAIT;
              end else begin
                state_d = S_OPEN_RD;
              end
            end
            OP_READ, OP_WRITE: begin
              len_d    = in_i.request_length;
              wr_d     = (opcode_e'(in_i.opcode) == OP_WRITE);
              done_d   = '0;
              k_d      = '0;
              remain_d = (off_q > cs) ? 26'd0 : cs - off_q;
              if (in_i.request_length == 32'd0) begin
                oa_d = '0;  olen_d = '0;  ow_d = wr_d;  odone_d = '0;
                ost_d = ST_OK;  ol_d = 1'b1;  ov_d = 1'b1;
                state_d = S_WAIT;
              end else begin
                state_d = S_TR_SEG;
              end
            end
            default: ;
          endcase
        end
      end
      S_OPEN_RD: state_d = S_OPEN_CHK;
      S_OPEN_CHK: begin
        oa_d = '0;  olen_d = '0;  ow_d = 1'b0;  odone_d = '0;  ol_d = 1'b1;
        if (!nx_ok) begin
          cur_d = nx;  off_d = cs;
          ost_d = (nx == 32'd0) ? ST_PREMATURE : ST_INVALID;
          ov_d = 1'b1;  state_d = S_WAIT;
        end else begin
          walk_d = nx[FatAw-1:0];
          cnt_d  = cnt_q + 1'b1;
          state_d = S_OPEN_RD;
          unique case (phase_q)
            PH_TAIL: begin
              if (cnt_q + 1'b1 == target_q) begin
                if (n_q > 48'(FatEntries)) begin
                  // Deep enough to be inside the loop: measure its period
                  phase_d = PH_CYCLE;
                  mark_d  = nx[FatAw-1:0];
                  per_d   = '0;
                end else begin
                  cur_d = {20'b0, nx[FatAw-1:0]};
                  off_d = fin_off[25:0];
                  ost_d = ST_OK;  ov_d = 1'b1;  state_d = S_WAIT;
                end
              end
            end
            PH_CYCLE: begin
              per_d = per_q + 1'b1;
              if (nx[FatAw-1:0] == mark_q) begin
                num_d  = n_q - 48'(FatEntries);
                rem_d  = '0;
                dcnt_d = '0;
                state_d = S_OPEN_DIV;
              end
            end
            PH_REST: begin
              if (cnt_q + 1'b1 == target_q) begin
                cur_d = {20'b0, nx[FatAw-1:0]};
                off_d = fin_off[25:0];
                ost_d = ST_OK;  ov_d = 1'b1;  state_d = S_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_OPEN_DIV: begin
        // Restoring division, one quotient bit a cycle; only the remainder is kept
        rem_d  = (rem_sh >= {1'b0, per_q}) ? rem_sh - {1'b0, per_q} : rem_sh;
        num_d  = num_q << 1;
        dcnt_d = dcnt_q + 6'd1;
        if (dcnt_q == 6'd47) begin
          if (rem_d == '0) begin
            cur_d = {20'b0, walk_q};
            off_d = fin_off[25:0];
            oa_d = '0;  olen_d = '0;  ow_d = 1'b0;  odone_d = '0;
            ost_d = ST_OK;  ol_d = 1'b1;  ov_d = 1'b1;  state_d = S_WAIT;
          end else begin
            phase_d  = PH_REST;
            cnt_d    = '0;
            target_d = WalkCntW'(rem_d);
            state_d  = S_OPEN_RD;
          end
        end
      end
      S_TR_SEG: state_d = (remain_q == 26'd0) ? S_TR_RD : S_TR_ADDR;
      S_TR_RD:  state_d = S_TR_CHK;
      S_TR_CHK: begin
        if (!nx_ok) begin
          oa_d = '0;  olen_d = '0;  ow_d = wr_q;  odone_d = done_q;
          ost_d = (nx == 32'hFFFF_FFFF) ? ST_END : ST_INVALID;
          ol_d = 1'b1;  ov_d = 1'b1;  state_d = S_WAIT;
        end else begin
          cur_d = nx;  off_d = '0;  remain_d = cs;
          state_d = S_TR_ADDR;
        end
      end
      S_TR_ADDR: begin
        t_d   = {32'b0, dss_q} + ({32'b0, cur_q - 32'd2} << spc_q);
        seg_d = (len_q < {6'b0, remain_q}) ? len_q[25:0] : remain_q;
        state_d = S_TR_EMIT;
      end
      S_TR_EMIT: begin
        oa_d     = (t_q << bps_q) + {38'b0, off_q};
        olen_d   = seg_q;
        ow_d     = wr_q;
        odone_d  = done_q + {6'b0, seg_q};
        done_d   = odone_d;
        len_d    = len_after;
        off_d    = off_q + seg_q;
        remain_d = remain_q - seg_q;
        k_d      = k_q + 1'b1;
        ol_d     = (len_after == 32'd0) || (k_d == SegCntW'(MaxSegments));
        ost_d    = (len_after != 32'd0 && k_d == SegCntW'(MaxSegments)) ? ST_TRUNCATED
                                                                        : ST_OK;
        ov_d     = 1'b1;
        state_d  = S_WAIT;
      end
      S_WAIT: begin
        // Hold until the result beat is taken
        if (!ov_d) state_d = ol_q ? S_IDLE : S_TR_SEG;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_o.valid           = ov_q;
  assign out_o.segment_address = oa_q;
  assign out_o.segment_length  = olen_q;
  assign out_o.is_write        = ow_q;
  assign out_o.transferred     = odone_q;
  assign out_o.status          = ost_q;
  assign out_o.last            = ol_q;

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid) else $error("result pending while idle");
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_TRUNCATED) |-> out_o.last)
    else $error("truncated beat not last");
  a_error_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == ST_END || out_o.status == ST_INVALID ||
     out_o.status == ST_PREMATURE)) |-> (out_o.segment_length == 26'd0 && out_o.last))
    else $error("error beat carries data");

endmodule
